// File: rtl/tcpmss_pkg.sv
// shared types and constants for the tcp option mss extractor
`default_nettype none

package tcpmss_pkg;

  // header layout
  localparam int unsigned MAX_HDR_BYTES_DEF = 64;
  localparam int unsigned HLEN_W            = 6;
  localparam int unsigned DOFF_BYTE         = 12;
  localparam int unsigned MIN_HDR           = 20;

  // option kinds and lengths
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] MSS_LEN     = 8'd4;
  localparam logic [7:0] MIN_OPT_LEN = 8'd2;

  // option walk phases
  typedef enum logic [4:0] {
    PH_KIND   = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_MSS_HI = 5'b01000,
    PH_MSS_LO = 5'b10000
  } phase_t;

  // one header byte as held in the input register
  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       last;
  } step_t;

  // one finished result
  typedef struct packed {
    logic [15:0]       mss;
    logic              mss_found;
    logic [HLEN_W-1:0] header_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/tcpmss_in_reg.sv
// input register stage for header byte transfers
`default_nettype none

module tcpmss_in_reg
  import tcpmss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_hdr_byte,
  input  wire logic       in_last,
  output logic            step_valid,
  output step_t           step,
  input  wire logic       step_take
);

  logic  valid_r;
  logic  valid_nxt;
  step_t step_r;
  logic  load;

  // hold while the parser cannot take the staged byte
  assign in_stall = valid_r && !step_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (step_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      step_r.hdr_byte <= in_hdr_byte;
      step_r.last     <= in_last;
    end
  end

  assign step_valid = valid_r;
  assign step       = step_r;

endmodule

`default_nettype wire

// File: rtl/tcpmss_parser.sv
// per-byte option walk state and result build
`default_nettype none

module tcpmss_parser
  import tcpmss_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MAX_HDR_BYTES_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step_en,
  input  wire step_t step,
  output logic       res_valid,
  output result_t    res
);

  localparam int unsigned POS_W   = $clog2(MAX_HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_HEADER_BYTES - 1);

  logic [POS_W-1:0]  pos_r,        pos_nxt;
  logic [HLEN_W-1:0] hdr_len_r,    hdr_len_nxt;
  phase_t            phase_r,      phase_nxt;
  logic [7:0]        kind_r,       kind_nxt;
  logic [HLEN_W-1:0] opt_start_r,  opt_start_nxt;
  logic [7:0]        skip_r,       skip_nxt;
  logic [7:0]        mss_hi_r,     mss_hi_nxt;
  logic [15:0]       mss_val_r,    mss_val_nxt;
  logic              mss_seen_r,   mss_seen_nxt;
  logic              stopped_r,    stopped_nxt;

  logic       walk;
  logic [8:0] pos_ext;
  logic [8:0] hlen_ext;
  logic [8:0] opt_end;
  logic [7:0] b;
  logic [7:0] skip_dec;

  assign b        = step.hdr_byte;
  assign pos_ext  = 9'(pos_r);
  assign hlen_ext = 9'(hdr_len_r);
  assign opt_end  = 9'(opt_start_r) + 9'(b);
  assign skip_dec = skip_r - 8'(skip_r != 8'd0);

  // byte is inside the option area and the walk is still running
  assign walk = !stopped_r && (pos_ext >= 9'(MIN_HDR)) && (pos_ext < hlen_ext);

  always_comb begin
    pos_nxt       = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
    hdr_len_nxt   = hdr_len_r;
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    opt_start_nxt = opt_start_r;
    skip_nxt      = skip_r;
    mss_hi_nxt    = mss_hi_r;
    mss_val_nxt   = mss_val_r;
    mss_seen_nxt  = mss_seen_r;
    stopped_nxt   = stopped_r;

    if (pos_ext == 9'(DOFF_BYTE)) begin
      // data offset in words, times four
      hdr_len_nxt = {b[7:4], 2'b00};
    end else if (walk) begin
      unique case (phase_r)
        PH_KIND: begin
          if (b == KIND_NOP) begin
            phase_nxt = PH_KIND;
          end else if (b == KIND_EOL || pos_ext + 9'd2 > hlen_ext) begin
            stopped_nxt = 1'b1;
          end else begin
            kind_nxt      = b;
            opt_start_nxt = HLEN_W'(pos_r);
            phase_nxt     = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < MIN_OPT_LEN || opt_end > hlen_ext) begin
            stopped_nxt = 1'b1;
          end else if (kind_r == KIND_MSS && b == MSS_LEN) begin
            phase_nxt = PH_MSS_HI;
          end else begin
            skip_nxt  = b - MIN_OPT_LEN;
            phase_nxt = (b == MIN_OPT_LEN) ? PH_KIND : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_KIND;
          end
        end
        PH_MSS_HI: begin
          mss_hi_nxt = b;
          phase_nxt  = PH_MSS_LO;
        end
        PH_MSS_LO: begin
          mss_val_nxt  = {mss_hi_r, b};
          mss_seen_nxt = 1'b1;
          phase_nxt    = PH_KIND;
        end
        default: begin
          stopped_nxt = 1'b1;
        end
      endcase
    end
  end

  // result from the state after this byte
  assign res_valid         = step_en && step.last;
  assign res.mss           = mss_seen_nxt ? mss_val_nxt : 16'd0;
  assign res.mss_found     = mss_seen_nxt;
  assign res.header_length = hdr_len_nxt;

  // state update; the last byte of a header returns to the start state
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step.last)) begin
      pos_r       <= '0;
      hdr_len_r   <= '0;
      phase_r     <= PH_KIND;
      kind_r      <= '0;
      opt_start_r <= '0;
      skip_r      <= '0;
      mss_hi_r    <= '0;
      mss_val_r   <= '0;
      mss_seen_r  <= 1'b0;
      stopped_r   <= 1'b0;
    end else if (step_en) begin
      pos_r       <= pos_nxt;
      hdr_len_r   <= hdr_len_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      opt_start_r <= opt_start_nxt;
      skip_r      <= skip_nxt;
      mss_hi_r    <= mss_hi_nxt;
      mss_val_r   <= mss_val_nxt;
      mss_seen_r  <= mss_seen_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcpmss_out_reg.sv
// result register for the output channel
`default_nettype none

module tcpmss_out_reg
  import tcpmss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_valid,
  input  wire result_t      res,
  output logic              res_ready,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [15:0]       out_mss,
  output logic              out_mss_found,
  output logic [HLEN_W-1:0] out_header_length
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    load;

  // free when empty or when the held result leaves this cycle
  assign res_ready = !valid_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_mss           = res_r.mss;
  assign out_mss_found     = res_r.mss_found;
  assign out_header_length = res_r.header_length;

endmodule

`default_nettype wire

// File: rtl/tcp_option_mss_extractor.sv
// top level of the tcp option mss extractor
//
//   channel  direction  payload                                   handshake
//   in_      input      hdr_byte[7:0], last                       in_valid / in_stall
//   out_     output     mss[15:0], mss_found, header_length[5:0]  out_valid / out_stall
//
// one header byte per cycle unless a byte marked last waits on a stalled result; a byte
// is held in the input register, and the result of a byte marked last is loaded into the
// result register as that byte moves on; the option walk state updates once per byte
// rst_n is synchronous; it empties both registers and clears the walk state
// a stalled result holds only a byte marked last in the input register;
// other bytes keep flowing while the result waits
`default_nettype none

module tcp_option_mss_extractor
  import tcpmss_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = MAX_HDR_BYTES_DEF
)
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_hdr_byte,
  input  wire logic         in_last,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [15:0]       out_mss,
  output logic              out_mss_found,
  output logic [HLEN_W-1:0] out_header_length
);

  logic    step_valid;
  step_t   step;
  logic    step_take;
  logic    res_valid;
  result_t res;
  logic    res_ready;

  // a staged byte moves on unless it is a last byte with the result slot full and stalled
  assign step_take = step_valid && (!step.last || res_ready);

  tcpmss_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_hdr_byte (in_hdr_byte),
    .in_last     (in_last),
    .step_valid  (step_valid),
    .step        (step),
    .step_take   (step_take)
  );

  tcpmss_parser #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_take),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  tcpmss_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .res_ready         (res_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mss           (out_mss),
    .out_mss_found     (out_mss_found),
    .out_header_length (out_header_length)
  );

endmodule

`default_nettype wire

// File: rtl/tcpmss_checker.sv
// port-level checks for the tcp option mss extractor, bound to the top level
`default_nettype none

module tcpmss_checker
  import tcpmss_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [15:0]       out_mss,
  input wire logic              out_mss_found,
  input wire logic [HLEN_W-1:0] out_header_length
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mss) &&
      $stable(out_mss_found) && $stable(out_header_length))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // no mss value without a captured option
  a_mss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mss_found |-> out_mss == 16'd0)
    else $error("mss reported without mss_found");

  // header length is a whole number of words
  a_hlen_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_header_length[1:0] == 2'b00)
    else $error("header length not a multiple of four");

endmodule

bind tcp_option_mss_extractor tcpmss_checker u_tcpmss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_mss           (out_mss),
  .out_mss_found     (out_mss_found),
  .out_header_length (out_header_length)
);

`default_nettype wire
